// File: design/sm4_pkg.sv
// shared constants, types and round functions for the sm4 block cipher core
package sm4_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int RC_BITS     = $clog2(ROUND_COUNT);

   // configuration register indexes
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   localparam logic [127:0] FAMILY_KEY = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

   typedef logic [ROUND_COUNT-1:0][31:0] rkeys_type;

   // one slot of the round pipeline
   typedef struct packed {
      logic         valid;
      logic         decrypt;
      logic [127:0] data;     // x0 in the top word, x3 in the bottom word
   } stage_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
      8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
      8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
      8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
      8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
      8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
      8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
      8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
      8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
      8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
      8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
      8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
      8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
      8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
      8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
   };

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // linear map of the data rounds
   function automatic logic [31:0] lin_data(input logic [31:0] b);
      return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
   endfunction

   // linear map of the key schedule
   function automatic logic [31:0] lin_key(input logic [31:0] b);
      return b ^ rotl32(b, 13) ^ rotl32(b, 23);
   endfunction

   // ck byte j, counted from the top, is (4i+j)*7 mod 256
   function automatic logic [31:0] round_const(input logic [RC_BITS-1:0] idx);
      logic [31:0] r;
      logic [7:0]  base;
      r    = '0;
      base = 8'({idx, 2'b00});
      for (int j = 0; j < 4; j++) begin
         r = {r[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return r;
   endfunction

endpackage

// File: design/sm4_round_cell.sv
// one cipher round: a pipeline cell that hands its block to the next cell
module sm4_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [31:0]         rk_enc,
   input  logic [31:0]         rk_dec,
   input  sm4_pkg::stage_type  stage_i,
   output sm4_pkg::stage_type  stage_o
);

   sm4_pkg::stage_type stage_ff;
   sm4_pkg::stage_type stage_in;
   logic [31:0]        rk;
   logic [31:0]        mix;
   logic [31:0]        x4;

   always_comb begin
      rk  = stage_i.decrypt ? rk_dec : rk_enc;
      mix = stage_i.data[95:64] ^ stage_i.data[63:32] ^ stage_i.data[31:0] ^ rk;
      x4  = stage_i.data[127:96] ^ sm4_pkg::lin_data(sm4_pkg::sub_word(mix));
      stage_in.valid   = stage_i.valid;
      stage_in.decrypt = stage_i.decrypt;
      stage_in.data    = {stage_i.data[95:0], x4};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.decrypt <= stage_in.decrypt;
         stage_ff.data    <= stage_in.data;
      end
   end

   assign stage_o = stage_ff;

endmodule

// File: design/sm4_key_sched.sv
// key registers and the iterative round key expansion, one key per cycle
module sm4_key_sched (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [63:0]         csr_write_data,
   output logic                busy,
   output sm4_pkg::rkeys_type  rkeys
);

   logic [63:0]                  key_high_ff, key_high_in;
   logic [63:0]                  key_low_ff,  key_low_in;
   logic [127:0]                 kw_ff;
   logic                         busy_ff;
   logic [sm4_pkg::RC_BITS-1:0]  cnt_ff;
   sm4_pkg::rkeys_type           rk_ff;
   logic [31:0]                  nk;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sm4_pkg::REG_KEY_HIGH: key_high_in = csr_write_data;
            sm4_pkg::REG_KEY_LOW:  key_low_in  = csr_write_data;
            default: ;
         endcase
      end
      nk = kw_ff[127:96] ^ sm4_pkg::lin_key(sm4_pkg::sub_word(
              kw_ff[95:64] ^ kw_ff[63:32] ^ kw_ff[31:0] ^ sm4_pkg::round_const(cnt_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         kw_ff       <= sm4_pkg::FAMILY_KEY;
         cnt_ff      <= '0;
         busy_ff     <= 1'b1;
      end else if (csr_write_enable) begin
         // restart the expansion from the new key
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         kw_ff       <= {key_high_in, key_low_in} ^ sm4_pkg::FAMILY_KEY;
         cnt_ff      <= '0;
         busy_ff     <= 1'b1;
      end else if (busy_ff) begin
         kw_ff   <= {kw_ff[95:0], nk};
         cnt_ff  <= cnt_ff + 1'b1;
         busy_ff <= (cnt_ff != sm4_pkg::RC_BITS'(sm4_pkg::ROUND_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !csr_write_enable) begin
         rk_ff[cnt_ff] <= nk;
      end
   end

   assign busy  = busy_ff;
   assign rkeys = rk_ff;

endmodule

// File: design/sm4_block_cipher_core.sv
// top level of the sm4 block cipher core: key schedule and a chain of round cells
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_action, req_block_high, req_block_low
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_result_high, rsp_result_low
//   csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// one block enters per cycle while req_stall is low; each round cell registers the block
// and applies one round to it, and rsp_valid rises when it leaves the last cell of the chain.
// after reset and after every key write the schedule expands the round keys, one per
// cycle, and req_stall stays high until the expansion is done.
// a stalled result freezes the whole chain and raises req_stall.
module sm4_block_cipher_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_action,
   input  logic [63:0]  req_block_high,
   input  logic [63:0]  req_block_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_result_high,
   output logic [63:0]  rsp_result_low,
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [63:0]  csr_write_data
);

   localparam int RC = sm4_pkg::ROUND_COUNT;

   logic                keys_busy;
   sm4_pkg::rkeys_type  rkeys;
   sm4_pkg::stage_type  chain [RC+1];
   logic                advance;
   logic [127:0]        last_data;

   sm4_key_sched u_key_sched (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .busy             (keys_busy),
      .rkeys            (rkeys)
   );

   assign advance   = !(chain[RC].valid && rsp_stall);
   assign req_stall = keys_busy || !advance;

   assign chain[0] = {req_valid && !req_stall, req_action, req_block_high, req_block_low};

   for (genvar i = 0; i < RC; i++) begin : g_round
      sm4_round_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .rk_enc  (rkeys[i]),
         .rk_dec  (rkeys[RC-1-i]),
         .stage_i (chain[i]),
         .stage_o (chain[i+1])
      );
   end

   // output words come out in reversed order
   assign last_data       = chain[RC].data;
   assign rsp_valid       = chain[RC].valid;
   assign rsp_result_high = {last_data[31:0], last_data[63:32]};
   assign rsp_result_low  = {last_data[95:64], last_data[127:96]};

endmodule

// File: sim/tb_sm4_block_cipher_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the sm4 block cipher core: directed vectors, then random traffic
module tb_sm4_block_cipher_core;

   localparam int   ROUNDS      = 32;
   localparam int   STALL_LIMIT = 2000;
   localparam int   DRAIN_TAIL  = 64;
   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   localparam logic [0:255][7:0] S_TABLE = {
      128'hD690E9FECCE13DB716B614C228FB2C05, 128'h2B679A762ABE04C3AA44132649860699,
      128'h9C4250F491EF987A33540B43EDCFAC62, 128'hE4B31CA9C908E89580DF94FA758F3FA6,
      128'h4707A7FCF37317BA83593C19E6854FA8, 128'h686B81B27164DA8BF8EB0F4B70569D35,
      128'h1E240E5E6358D1A225227C3B01217887, 128'hD40046579FD327524C3602E7A0C4C89E,
      128'hEABF8AD240C738B5A3F7F2CEF96115A1, 128'hE0AE5DA49B341A55AD933230F58CB1E3,
      128'h1DF6E22E8266CA60C02923AB0D534E6F, 128'hD5DB3745DEFD8E2F03FF6A726D6C5B51,
      128'h8D1BAF92BBDDBC7F11D95C411F105AD8, 128'h0AC13188A5CD7BBD2D74D012B8E5B4B0,
      128'h8969974A0C96777E65B9F109C56EC684, 128'h18F07DEC3ADC4D2079EE5F3ED7CB3948
   };

   typedef logic [31:0] word_t;
   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block_t;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_action       = 1'b0;
   logic [63:0] req_block_high   = '0;
   logic [63:0] req_block_low    = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = 1'b0;
   logic [63:0] csr_write_data   = '0;

   logic [63:0] cipher_key_high = '0;
   logic [63:0] cipher_key_low  = '0;
   word_t       round_keys [ROUNDS];
   block_t      predicted_outputs [$];
   int          errors       = 0;
   int          max_req_gap  = 15;
   int          max_rsp_hold = 15;
   int          hold_cycles  = 0;
   int          idle_cycles  = 0;

   sm4_block_cipher_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic word_t rot_left(word_t v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic word_t tau(word_t v);
      return {S_TABLE[v[31:24]], S_TABLE[v[23:16]], S_TABLE[v[15:8]], S_TABLE[v[7:0]]};
   endfunction

   // ck byte j from the top is (4i+j)*7 mod 256
   function automatic word_t ck_word(int i);
      word_t r;
      r = '0;
      for (int j = 0; j < 4; j++) r = {r[23:0], 8'((4 * i + j) * 7)};
      return r;
   endfunction

   function automatic void schedule_round_keys();
      word_t k [4];
      word_t b;
      k[0] = cipher_key_high[63:32] ^ 32'hA3B1BAC6;
      k[1] = cipher_key_high[31:0]  ^ 32'h56AA3350;
      k[2] = cipher_key_low[63:32]  ^ 32'h677D9197;
      k[3] = cipher_key_low[31:0]   ^ 32'hB27022DC;
      for (int i = 0; i < ROUNDS; i++) begin
         b = tau(k[1] ^ k[2] ^ k[3] ^ ck_word(i));
         b = k[0] ^ b ^ rot_left(b, 13) ^ rot_left(b, 23);
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = b;
         round_keys[i] = b;
      end
   endfunction

   function automatic block_t sm4_crypt(logic decrypt, block_t blk);
      word_t  x [4];
      word_t  b;
      word_t  t;
      block_t res;
      x[0] = blk.high[63:32];
      x[1] = blk.high[31:0];
      x[2] = blk.low[63:32];
      x[3] = blk.low[31:0];
      for (int i = 0; i < ROUNDS; i++) begin
         b = tau(x[1] ^ x[2] ^ x[3] ^ round_keys[decrypt ? ROUNDS - 1 - i : i]);
         t = x[0] ^ b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = t;
      end
      res.high = {x[3], x[2]};
      res.low  = {x[1], x[0]};
      return res;
   endfunction

   function automatic logic [63:0] random_key_half();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic block_t random_block();
      block_t b;
      b.high = {$urandom(), $urandom()};
      b.low  = {$urandom(), $urandom()};
      case ($urandom_range(0, 15))
         0:       b = '0;
         1:       b = '1;
         default: ;
      endcase
      return b;
   endfunction

   function automatic int idle_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 15;
      endcase
   endfunction

   task automatic send_block(input logic action, input block_t blk, output block_t result);
      int gap;
      gap = $urandom_range(0, max_req_gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_action     <= action;
      req_block_high <= blk.high;
      req_block_low  <= blk.low;
      do @(posedge clock); while (req_stall);
      result = sm4_crypt(action, blk);
      predicted_outputs.push_back(result);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
   endtask

   // the core stalls requests while it re-expands, so the next block sees the new key
   task automatic write_key(input logic idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == sm4_pkg::REG_KEY_HIGH) cipher_key_high = value;
      else cipher_key_low = value;
      schedule_round_keys();
   endtask

   task automatic load_key(input logic [63:0] high, input logic [63:0] low);
      write_key(sm4_pkg::REG_KEY_HIGH, high);
      write_key(sm4_pkg::REG_KEY_LOW, low);
   endtask

   task automatic test_reset_key();
      block_t r;
      send_block(ACT_ENCRYPT, '0, r);
      send_block(ACT_DECRYPT, '0, r);
      send_block(ACT_ENCRYPT, '1, r);
      send_block(ACT_DECRYPT, '1, r);
      wait_for_drain();
   endtask

   task automatic test_standard_vector();
      block_t r;
      load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      send_block(ACT_ENCRYPT, {64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, r);
      if (r !== {64'h681EDF34D206965E, 64'h86B3E94F536E4246}) begin
         $error("known ciphertext mismatch: expected 681edf34d206965e86b3e94f536e4246, actual %h",
                r);
         errors++;
      end
      send_block(ACT_DECRYPT, {64'h681EDF34D206965E, 64'h86B3E94F536E4246}, r);
      wait_for_drain();
   endtask

   task automatic test_key_extremes();
      block_t r;
      load_key('1, '1);
      send_block(ACT_ENCRYPT, {64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA}, r);
      send_block(ACT_DECRYPT, {64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555}, r);
      send_block(ACT_ENCRYPT, {64'h8000000000000000, 64'h0000000000000001}, r);
      send_block(ACT_DECRYPT, {64'h0000000000000001, 64'h8000000000000000}, r);
      wait_for_drain();
      // single register writes, each followed by a block
      write_key(sm4_pkg::REG_KEY_HIGH, '0);
      send_block(ACT_ENCRYPT, '1, r);
      wait_for_drain();
      write_key(sm4_pkg::REG_KEY_LOW, 64'h8000000000000001);
      send_block(ACT_DECRYPT, '0, r);
      wait_for_drain();
   endtask

   task automatic test_pause_until_drained();
      block_t r;
      max_req_gap  = 0;
      max_rsp_hold = 15;
      repeat (3) begin
         repeat (8) send_block(1'($urandom_range(0, 1)), random_block(), r);
         wait_for_drain();
      end
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      int     sent;
      int     next_switch;
      logic   act;
      block_t blk;
      block_t out;
      block_t back;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 2))
            0:       write_key(sm4_pkg::REG_KEY_HIGH, random_key_half());
            1:       write_key(sm4_pkg::REG_KEY_LOW, random_key_half());
            default: load_key(random_key_half(), random_key_half());
         endcase
         sent        = 0;
         next_switch = 0;
         while (sent < per_phase) begin
            if (sent >= next_switch) begin
               max_req_gap  = idle_limit();
               max_rsp_hold = idle_limit();
               next_switch  = sent + 64;
            end
            act = 1'($urandom_range(0, 1));
            blk = random_block();
            send_block(act, blk, out);
            sent++;
            // mostly round trips: the result goes straight back the other way
            if ($urandom_range(0, 9) < 7) begin
               send_block(~act, out, back);
               sent++;
            end
         end
         wait_for_drain();
      end
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      block_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outputs.size() == 0) begin
            $error("result transfer with nothing expected: %h %h", rsp_result_high,
                   rsp_result_low);
            errors++;
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_result_high !== want.high) begin
               $error("result_high mismatch: expected %h, actual %h", want.high,
                      rsp_result_high);
               errors++;
            end
            if (rsp_result_low !== want.low) begin
               $error("result_low mismatch: expected %h, actual %h", want.low, rsp_result_low);
               errors++;
            end
         end
         hold_cycles = $urandom_range(0, max_rsp_hold);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      schedule_round_keys();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_standard_vector();
      test_key_extremes();
      test_pause_until_drained();
      test_random_traffic(8, 232);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (predicted_outputs.size() != 0) begin
         $error("%0d expected results never arrived", predicted_outputs.size());
         errors++;
      end
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
design/sm4_pkg.sv
design/sm4_round_cell.sv
design/sm4_key_sched.sv
design/sm4_block_cipher_core.sv
sim/tb_sm4_block_cipher_core.sv
